// ===== rtl/cprt_pkg.sv =====
// Types, codes and constants shared by the chunk presence tracker modules.
`default_nettype none

package cprt_pkg;

  // Field widths of the transaction payloads
  localparam int unsigned BYTE_W   = 23;  // byte positions and byte counts
  localparam int unsigned CNT_W    = 7;   // chunk counts
  localparam int unsigned IDX_W    = 6;   // chunk index field
  localparam int unsigned RANGE_W  = 32;  // range offset and length fields
  localparam int unsigned CFG_W    = 23;  // configuration write data
  localparam int unsigned POS_W    = 24;  // internal byte position, saturating

  // Internal positions saturate here: above every legal total_bytes value
  localparam logic [POS_W-1:0]  POS_SAT  = 24'h800000;
  localparam logic [BYTE_W-1:0] BYTE_MAX = 23'h7FFFFF;

  // Runs per query
  localparam int unsigned          RUN_CNT_W = 6;
  localparam logic [RUN_CNT_W-1:0] MAX_RUNS  = 6'd32;

  typedef enum logic [1:0] {
    OP_MARK_SET      = 2'd0,
    OP_MARK_CLR      = 2'd1,
    OP_QUERY_MISSING = 2'd2,
    OP_LIST_PRESENT  = 2'd3
  } cprt_op_e;

  typedef enum logic [0:0] {
    REG_TOTAL_BYTES = 1'b0,
    REG_CHUNK_COUNT = 1'b1
  } cprt_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STAT,
    ST_SUM,
    ST_WALK,
    ST_CLOSE,
    ST_DONE
  } cprt_state_e;

  typedef struct packed {
    cprt_op_e             opcode;
    logic [IDX_W-1:0]     chunk_sel;
    logic [RANGE_W-1:0]   range_offset;
    logic [RANGE_W-1:0]   range_length;
  } cprt_in_t;

  typedef struct packed {
    logic                 run_valid;
    logic [BYTE_W-1:0]    run_start;
    logic [BYTE_W-1:0]    run_bytes;
    logic                 range_complete;
    logic [CNT_W-1:0]     present_chunks;
    logic [BYTE_W-1:0]    present_bytes;
    logic                 last;
  } cprt_out_t;

  // Controller to datapath
  typedef struct packed {
    logic stat;        // form the byte-total products
    logic sum;         // finish the byte total, arm the walk
    logic walk;        // process one chunk
    logic close;       // tail run or open present run
    logic final_emit;  // deliver the closing result
  } cprt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic walk_last;
    logic n_zero;
    logic is_query;
  } cprt_sts_t;

endpackage

`default_nettype wire

// ===== rtl/cprt_ctrl.sv =====
// Sequencing state machine of the chunk presence tracker.
`default_nettype none

module cprt_ctrl
  import cprt_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      accept_i,
  input  wire cprt_sts_t sts_i,
  output cprt_cmd_t      cmd_o,
  output logic           busy_o
);

  cprt_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept_i) state_d = ST_STAT;
      end
      ST_STAT: begin
        state_d = ST_SUM;
      end
      ST_SUM: begin
        if (!sts_i.is_query)   state_d = ST_DONE;
        else if (sts_i.n_zero) state_d = ST_CLOSE;
        else                   state_d = ST_WALK;
      end
      ST_WALK: begin
        if (sts_i.walk_last) state_d = ST_CLOSE;
      end
      ST_CLOSE: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Commands per state
  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      ST_IDLE:  busy_o           = 1'b0;
      ST_STAT:  cmd_o.stat       = 1'b1;
      ST_SUM:   cmd_o.sum        = 1'b1;
      ST_WALK:  cmd_o.walk       = 1'b1;
      ST_CLOSE: cmd_o.close      = 1'b1;
      ST_DONE:  cmd_o.final_emit = 1'b1;
      default:  busy_o           = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cprt_dp.sv =====
// Datapath: presence bitmap, configuration, byte totals and the run walker.
`default_nettype none

module cprt_dp
  import cprt_pkg::*;
#(
  parameter int unsigned MAX_CHUNKS  = 64,
  parameter int unsigned CHUNK_BYTES = 65536
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire cprt_in_t           item_i,
  input  wire logic               cfg_we_i,
  input  wire cprt_reg_e          cfg_idx_i,
  input  wire logic [CFG_W-1:0]   cfg_data_i,
  input  wire cprt_cmd_t          cmd_i,
  output cprt_sts_t               sts_o,
  output logic                    result_valid_o,
  output cprt_out_t               result_o
);

  localparam int unsigned IW  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int unsigned PCW = $clog2(MAX_CHUNKS + 1);
  localparam int unsigned CAP = (MAX_CHUNKS < 127) ? MAX_CHUNKS : 127;
  localparam int unsigned XW  = (IW >= 7) ? IW + 1 : 8;
  localparam int unsigned LW  = CNT_W + POS_W;   // last chunk start product
  localparam int unsigned FPW = PCW + POS_W;     // full chunks product
  // Chunk size clipped to the saturation point of internal positions
  localparam logic [POS_W-1:0] CBC =
    (CHUNK_BYTES > 8388608) ? POS_SAT : POS_W'(CHUNK_BYTES);

  // Configuration and state
  logic [BYTE_W-1:0]     total_q;
  logic [CNT_W-1:0]      ccount_q;
  logic [MAX_CHUNKS-1:0] bits_q;
  logic [PCW-1:0]        pcnt_q;

  // Per transaction
  cprt_op_e              op_q;
  logic [BYTE_W-1:0]     off_q, endo_q;
  logic                  rok_q, zlen_q;
  logic [LW-1:0]         lst_q;
  logic [FPW-1:0]        fullp_q;
  logic                  lastbit_q;
  logic [BYTE_W-1:0]     pb_q;

  // Walker
  logic [IW-1:0]         idx_q;
  logic [POS_W-1:0]      cs_q;
  logic                  inrun_q;
  logic [POS_W-1:0]      prs_q, pre_q;
  logic                  pend_v_q;
  logic [BYTE_W-1:0]     pend_s_q, pend_e_q;
  logic [RUN_CNT_W-1:0]  rcnt_q;

  logic                  res_v_q;
  cprt_out_t             res_q;

  // Effective chunk count
  logic [CNT_W-1:0] neff, nm1;
  assign neff = (ccount_q > CNT_W'(CAP)) ? CNT_W'(CAP) : ccount_q;
  assign nm1  = neff - CNT_W'(1);

  // Marking
  logic          is_mark, mark_hit, mark_val, mark_old;
  logic [IW-1:0] mark_idx;
  always_comb begin
    is_mark  = (item_i.opcode == OP_MARK_SET) || (item_i.opcode == OP_MARK_CLR);
    mark_idx = IW'(item_i.chunk_sel);
    mark_val = (item_i.opcode == OP_MARK_SET);
    mark_old = bits_q[mark_idx];
    mark_hit = accept_i && is_mark && ({1'b0, item_i.chunk_sel} < neff);
  end

  // Range setup from the accepted item
  logic [RANGE_W:0]  rsum;
  logic              rok_in;
  always_comb begin
    rsum   = {1'b0, item_i.range_offset} + {1'b0, item_i.range_length};
    rok_in = (item_i.range_length != '0) &&
             (item_i.range_offset < RANGE_W'(total_q));
  end

  // Byte total products and sum
  logic             lastbit;
  logic [PCW-1:0]   fullc;
  logic [LW-1:0]    tot_l;
  logic [BYTE_W-1:0] lastbytes;
  logic [FPW:0]     bsum;
  always_comb begin
    lastbit   = (neff != '0) && bits_q[IW'(nm1)];
    fullc     = pcnt_q - PCW'(lastbit);
    tot_l     = LW'(total_q);
    lastbytes = (tot_l > lst_q) ? BYTE_W'(tot_l - lst_q) : '0;
    bsum      = (FPW+1)'(fullp_q) + (FPW+1)'(lastbit_q ? lastbytes : '0);
  end

  // Walk step: chunk bounds and run events
  logic [POS_W:0]   csn_w;
  logic [POS_W-1:0] csn, off24, endo24, tot24, lo, hi, ps, pe;
  logic             bit_p, is_miss, is_pres;
  logic             ev, merge, new_run;
  logic [POS_W-1:0] ev_s, ev_e;
  always_comb begin
    csn_w   = {1'b0, cs_q} + {1'b0, CBC};
    csn     = (csn_w > (POS_W+1)'(POS_SAT)) ? POS_SAT : csn_w[POS_W-1:0];
    off24   = POS_W'(off_q);
    endo24  = POS_W'(endo_q);
    tot24   = POS_W'(total_q);
    lo      = (off24 > cs_q) ? off24 : cs_q;
    hi      = (csn < endo24) ? csn : endo24;
    ps      = (prs_q < tot24) ? prs_q : tot24;
    pe      = (pre_q < tot24) ? pre_q : tot24;
    bit_p   = bits_q[idx_q];
    is_miss = (op_q == OP_QUERY_MISSING);
    is_pres = (op_q == OP_LIST_PRESENT);
    ev      = 1'b0;
    ev_s    = lo;
    ev_e    = hi;
    if (cmd_i.walk) begin
      if (is_miss) begin
        ev = rok_q && (csn > off24) && (lo < endo24) && !bit_p;
      end else if (is_pres && inrun_q && !bit_p) begin
        ev   = (pe > ps);
        ev_s = ps;
        ev_e = pe;
      end
    end else if (cmd_i.close) begin
      if (is_miss) begin
        ev   = rok_q && (lo < endo24);
        ev_e = endo24;
      end else if (is_pres && inrun_q) begin
        ev   = (pe > ps);
        ev_s = ps;
        ev_e = pe;
      end
    end
    merge   = ev && is_miss && pend_v_q && (pend_e_q == ev_s[BYTE_W-1:0]);
    new_run = ev && !merge && (rcnt_q < MAX_RUNS);
  end

  // Result formation
  logic      emit;
  cprt_out_t emit_res;
  always_comb begin
    emit                    = 1'b0;
    emit_res.run_valid      = pend_v_q;
    emit_res.run_start      = pend_v_q ? pend_s_q : '0;
    emit_res.run_bytes      = pend_v_q ? (pend_e_q - pend_s_q) : '0;
    emit_res.range_complete = 1'b0;
    emit_res.present_chunks = CNT_W'(pcnt_q);
    emit_res.present_bytes  = pb_q;
    emit_res.last           = 1'b0;
    if (new_run && pend_v_q) begin
      emit = 1'b1;
    end else if (cmd_i.final_emit) begin
      emit          = 1'b1;
      emit_res.last = 1'b1;
      if (!pend_v_q) begin
        emit_res.range_complete = is_miss && (zlen_q || rok_q);
      end
    end
  end

  // Status for the controller
  always_comb begin
    sts_o.walk_last = ((XW'(idx_q) + XW'(1)) == XW'(neff));
    sts_o.n_zero    = (neff == '0);
    sts_o.is_query  = is_miss || is_pres;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q  <= '0;
      ccount_q <= '0;
      bits_q   <= '0;
      pcnt_q   <= '0;
      op_q     <= OP_MARK_SET;
      inrun_q  <= 1'b0;
      pend_v_q <= 1'b0;
      rcnt_q   <= '0;
      idx_q    <= '0;
      res_v_q  <= 1'b0;
    end else begin
      res_v_q <= emit;
      // Configuration writes; a new chunk count drops all presence
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TOTAL_BYTES: total_q <= cfg_data_i;
          REG_CHUNK_COUNT: begin
            ccount_q <= cfg_data_i[CNT_W-1:0];
            bits_q   <= '0;
            pcnt_q   <= '0;
          end
          default: ;
        endcase
      end else if (mark_hit && (mark_old != mark_val)) begin
        bits_q[mark_idx] <= mark_val;
        pcnt_q           <= mark_val ? pcnt_q + PCW'(1) : pcnt_q - PCW'(1);
      end
      if (accept_i) op_q <= item_i.opcode;
      // Arm the walk
      if (cmd_i.sum) begin
        idx_q    <= '0;
        inrun_q  <= 1'b0;
        pend_v_q <= 1'b0;
        rcnt_q   <= '0;
      end
      if (cmd_i.walk) begin
        idx_q <= idx_q + IW'(1);
        if (is_pres) inrun_q <= bit_p;
      end
      if (cmd_i.close) inrun_q <= 1'b0;
      if (new_run) begin
        pend_v_q <= 1'b1;
        rcnt_q   <= rcnt_q + RUN_CNT_W'(1);
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      off_q  <= item_i.range_offset[BYTE_W-1:0];
      endo_q <= (rsum < (RANGE_W+1)'(total_q)) ? rsum[BYTE_W-1:0] : total_q;
      rok_q  <= rok_in;
      zlen_q <= (item_i.range_length == '0);
    end
    if (cmd_i.stat) begin
      lst_q     <= LW'(nm1) * LW'(CBC);
      fullp_q   <= FPW'(fullc) * FPW'(CBC);
      lastbit_q <= lastbit;
    end
    if (cmd_i.sum) begin
      pb_q <= (bsum > (FPW+1)'(BYTE_MAX)) ? BYTE_MAX : bsum[BYTE_W-1:0];
      cs_q <= '0;
    end
    if (cmd_i.walk) begin
      cs_q <= csn;
      if (bit_p && !inrun_q) prs_q <= cs_q;
      if (bit_p)             pre_q <= csn;
    end
    // Merge into the held run, open a new one, or stretch the capped one
    if (merge) begin
      pend_e_q <= ev_e[BYTE_W-1:0];
    end else if (new_run) begin
      pend_s_q <= ev_s[BYTE_W-1:0];
      pend_e_q <= ev_e[BYTE_W-1:0];
    end else if (ev && is_miss) begin
      pend_e_q <= ev_e[BYTE_W-1:0];
    end
    if (emit) res_q <= emit_res;
  end

  assign result_valid_o = res_v_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire

// ===== rtl/chunk_presence_range_tracker_core.sv =====
// Top level of the chunk presence tracker: controller and datapath.
//
// Usage:
// - Command channel: a transaction is taken at a clock edge where start is
//   high and busy is low. Opcodes mark a chunk present or absent, query the
//   missing runs of a byte range, or list the present runs.
// - Result channel: each result is shown for one cycle with result_valid_o;
//   the receiver cannot stall. The final result of a transaction has last set.
// - Configuration: cfg_we_i writes total_bytes (index 0) or chunk_count
//   (index 1) at once; writing chunk_count clears every presence bit.
//   Write only while busy is low.
// - Timing: a mark holds busy through the STAT, SUM and DONE states; its single
//   result is on the ports in the cycle busy falls. A query holds busy through
//   STAT, SUM, the walk over the effective chunks, CLOSE and DONE, and the walker
//   visits one presence bit per cycle; runs come out as they close, the last
//   one in the cycle busy falls.
// - Transactions: one at a time; the next is taken at the edge ending the
//   cycle busy falls.
// - Reset: all presence bits cleared, both registers zero, block idle.
`default_nettype none

module chunk_presence_range_tracker_core
  import cprt_pkg::*;
#(
  parameter int unsigned MAX_CHUNKS  = 64,
  parameter int unsigned CHUNK_BYTES = 65536
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire cprt_in_t         item_i,
  output logic                  result_valid_o,
  output cprt_out_t             result_o,
  input  wire logic             cfg_we_i,
  input  wire cprt_reg_e        cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_data_i
);

  logic      accept;
  cprt_cmd_t cmd;
  cprt_sts_t sts;

  // Transaction acceptance
  assign accept = start && !busy;

  cprt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  cprt_dp #(
    .MAX_CHUNKS  (MAX_CHUNKS),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .item_i         (item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // The closing result lands exactly as busy drops
  a_fall_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (result_valid_o && result_o.last))
    else $error("busy fell without a final result");

  // Only the final result of a transaction is seen while idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.last == !busy))
    else $error("last flag out of step with busy");

  // A status-only result always closes its transaction
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.run_valid) |-> result_o.last)
    else $error("status-only result not final");

  // Runs are never empty and never report a complete range
  a_run_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.run_valid) |->
      ((result_o.run_bytes != '0) && !result_o.range_complete))
    else $error("empty run or complete flag on a run");

endmodule

`default_nettype wire

// ===== tb/chunk_presence_range_tracker_core_tb.sv =====
// Self-checking testbench for the chunk presence range tracker core.
module chunk_presence_range_tracker_core_tb;
  import cprt_pkg::*;

  localparam int unsigned     NUM_CHUNKS  = 64;
  localparam longint unsigned CHUNK_SZ    = 65536;
  localparam int              DIR_ROWS    = 26;
  localparam int              QUIET_LIMIT = 4000;

  // One row of the directed sequence
  typedef struct {
    bit          load;   // program both registers before this transaction
    logic [22:0] total;
    logic [6:0]  count;
    cprt_in_t    cmd;
    bit          typed;  // use the result typed in the row
    cprt_out_t   want;
  } dir_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  cprt_in_t          item_i = '0;
  logic              result_valid_o;
  cprt_out_t         result_o;
  logic              cfg_we_i = 1'b0;
  cprt_reg_e         cfg_idx_i = REG_TOTAL_BYTES;
  logic [CFG_W-1:0]  cfg_data_i = '0;

  // Tracker state as the predictor sees it
  logic [63:0]       chunk_present;
  logic [22:0]       value_size;
  logic [6:0]        chunk_total;
  longint unsigned   run_first [32];
  longint unsigned   run_end [32];
  int                run_cnt;
  cprt_out_t         step_results [32];
  int                step_count;

  cprt_out_t         expected_results [$];
  cprt_out_t         want_res;
  dir_row_t          dir_tab [DIR_ROWS];
  int                mismatch_count = 0;
  int                quiet_cycles = 0;
  int                idle_pct = 0;

  chunk_presence_range_tracker_core #(
    .MAX_CHUNKS (NUM_CHUNKS),
    .CHUNK_BYTES(32'(CHUNK_SZ))
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic cprt_in_t cmd(input cprt_op_e op, input logic [5:0] idx,
                                   input logic [31:0] off, input logic [31:0] len);
    cprt_in_t c;
    c.opcode       = op;
    c.chunk_sel    = idx;
    c.range_offset = off;
    c.range_length = len;
    return c;
  endfunction

  // Result with no run attached
  function automatic cprt_out_t status(input logic comp, input logic [6:0] pc,
                                       input logic [22:0] pb);
    cprt_out_t r;
    r = '0;
    r.range_complete = comp;
    r.present_chunks = pc;
    r.present_bytes  = pb;
    r.last           = 1'b1;
    return r;
  endfunction

  function automatic longint unsigned active_chunks();
    return (chunk_total > NUM_CHUNKS) ? NUM_CHUNKS : chunk_total;
  endfunction

  function automatic longint unsigned present_count();
    longint unsigned i, c;
    c = 0;
    for (i = 0; i < active_chunks(); i++)
      if (chunk_present[i]) c++;
    return c;
  endfunction

  // Present bytes; the last chunk only holds what lies below the value size
  function automatic longint unsigned held_bytes();
    longint unsigned n, sum, i, base;
    n = active_chunks();
    sum = 0;
    for (i = 0; i < n; i++) begin
      if (chunk_present[i]) begin
        if (i == n - 1) begin
          base = i * CHUNK_SZ;
          sum += (value_size > base) ? value_size - base : 64'd0;
        end else begin
          sum += CHUNK_SZ;
        end
        if (sum > BYTE_MAX) sum = BYTE_MAX;
      end
    end
    return sum;
  endfunction

  // Merge with the previous run when adjacent; past the cap, stretch the last run
  task automatic add_missing(input longint unsigned s, input longint unsigned e);
    if (run_cnt > 0 && run_end[run_cnt-1] == s) begin
      run_end[run_cnt-1] = e;
    end else if (run_cnt < MAX_RUNS) begin
      run_first[run_cnt] = s;
      run_end[run_cnt]   = e;
      run_cnt++;
    end else begin
      run_end[run_cnt-1] = e;
    end
  endtask

  // Update the tracker state for one transaction and form its results
  task automatic predict_outputs(input cprt_in_t t);
    longint unsigned off, len, endo, cur, ce, k, sc, ec, s, e, live, pc, pb;
    logic comp;
    off = t.range_offset;
    len = t.range_length;
    live = active_chunks();
    run_cnt = 0;
    comp = 1'b0;
    case (t.opcode)
      OP_MARK_SET, OP_MARK_CLR: begin
        if (t.chunk_sel < live) chunk_present[t.chunk_sel] = (t.opcode == OP_MARK_SET);
      end
      OP_QUERY_MISSING: begin
        if (len == 0) begin
          comp = 1'b1;
        end else if (off < value_size) begin
          endo = (off + len < value_size) ? off + len : value_size;
          sc = off / CHUNK_SZ;
          ec = (endo - 1) / CHUNK_SZ;
          comp = (ec < live);
          if (comp) begin
            for (k = sc; k <= ec; k++)
              if (!chunk_present[k]) comp = 1'b0;
          end
          // walk the covered chunks, collecting missing bytes
          cur = off;
          k = cur / CHUNK_SZ;
          while (cur < endo && k < live) begin
            ce = k * CHUNK_SZ + CHUNK_SZ;
            if (ce > value_size) ce = value_size;
            if (!chunk_present[k]) add_missing(cur, (ce < endo) ? ce : endo);
            cur = ce;
            k++;
          end
          // bytes beyond the chunk count are missing too
          if (cur < endo) add_missing(cur, endo);
        end
      end
      default: begin
        k = 0;
        while (k < live) begin
          if (chunk_present[k]) begin
            s = k * CHUNK_SZ;
            e = s;
            while (k < live && chunk_present[k]) begin
              e = (k + 1) * CHUNK_SZ;
              k++;
            end
            if (e > value_size) e = value_size;
            if (s > value_size) s = value_size;
            if (e > s && run_cnt < MAX_RUNS) begin
              run_first[run_cnt] = s;
              run_end[run_cnt]   = e;
              run_cnt++;
            end
          end else begin
            k++;
          end
        end
      end
    endcase
    pc = present_count();
    pb = held_bytes();
    if (run_cnt == 0) begin
      step_results[0] = status(comp, 7'(pc), 23'(pb));
      step_count = 1;
    end else begin
      for (k = 0; k < run_cnt; k++) begin
        step_results[k].run_valid      = 1'b1;
        step_results[k].run_start      = 23'(run_first[k]);
        step_results[k].run_bytes      = 23'(run_end[k] - run_first[k]);
        step_results[k].range_complete = comp;
        step_results[k].present_chunks = 7'(pc);
        step_results[k].present_bytes  = 23'(pb);
        step_results[k].last           = (k == run_cnt - 1);
      end
      step_count = run_cnt;
    end
  endtask

  // Random transaction, biased toward valid indexes and ranges near the value
  function automatic cprt_in_t rand_cmd(input bit query_only);
    cprt_in_t c;
    int unsigned r;
    longint unsigned live;
    live = active_chunks();
    c.chunk_sel    = 6'($urandom_range(0, 63));
    c.range_offset = $urandom;
    c.range_length = $urandom;
    r = $urandom_range(0, 99);
    if (query_only || (r >= 60 && r < 85)) c.opcode = OP_QUERY_MISSING;
    else if (r < 45) c.opcode = OP_MARK_SET;
    else if (r < 60) c.opcode = OP_MARK_CLR;
    else c.opcode = OP_LIST_PRESENT;
    if (live != 0 && $urandom_range(0, 4) != 0)
      c.chunk_sel = 6'($urandom_range(0, 32'(live - 1)));
    r = $urandom_range(0, 9);
    if (r < 5) c.range_offset = $urandom_range(0, value_size + 70000);
    else if (r < 7)
      c.range_offset = 32'($urandom_range(0, 70) * CHUNK_SZ + $urandom_range(0, 2) - 1);
    r = $urandom_range(0, 9);
    if (r == 0) c.range_length = 0;
    else if (r < 6) c.range_length = $urandom_range(1, 300000);
    else if (r < 8) c.range_length = $urandom_range(1, 8388607);
    return c;
  endfunction

  // Hold start low until every result is in and the block is free
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_results.size() != 0 || busy) @(posedge clk_i);
  endtask

  // Program value size, then chunk count (which also clears the bitmap)
  task automatic write_regs(input logic [22:0] tot, input logic [6:0] cnt);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_TOTAL_BYTES;
    cfg_data_i <= tot;
    @(posedge clk_i);
    value_size = tot;
    cfg_idx_i  <= REG_CHUNK_COUNT;
    cfg_data_i <= {16'd0, cnt};
    @(posedge clk_i);
    chunk_total   = cnt;
    chunk_present = '0;
    cfg_we_i <= 1'b0;
  endtask

  // Send one transaction and queue what it should produce
  task automatic issue(input cprt_in_t c, input bit typed, input cprt_out_t typed_res);
    int k;
    start  <= 1'b1;
    item_i <= c;
    do @(posedge clk_i); while (busy);
    predict_outputs(c);
    if (typed) expected_results = {expected_results, typed_res};
    else for (k = 0; k < step_count; k++)
      expected_results = {expected_results, step_results[k]};
    if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 80)) @(posedge clk_i);
    end
  endtask

  // One configuration, optionally an alternating bitmap, then random traffic
  task automatic run_phase(input logic [22:0] tot, input logic [6:0] cnt, input int pct,
                           input bit alternate, input bit odd, input int n_mixed);
    int k;
    write_regs(tot, cnt);
    idle_pct = pct;
    if (alternate) begin
      for (k = odd; k < 64; k += 2)
        issue(cmd(OP_MARK_SET, 6'(k), $urandom, $urandom), 1'b0, '0);
      issue(cmd(OP_QUERY_MISSING, 6'($urandom), 32'd0, 32'hFFFF_FFFF), 1'b0, '0);
      issue(rand_cmd(1'b1), 1'b0, '0);
      issue(cmd(OP_LIST_PRESENT, 6'($urandom), $urandom, $urandom), 1'b0, '0);
      issue(rand_cmd(1'b1), 1'b0, '0);
    end
    for (k = 0; k < n_mixed; k++) issue(rand_cmd(1'b0), 1'b0, '0);
  endtask

  task automatic check_field(input string name, input longint unsigned want,
                             input longint unsigned got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Result checker: every strobed result against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %p", $time, result_o);
        mismatch_count++;
      end else begin
        want_res = expected_results.pop_front();
        check_field("run_valid", want_res.run_valid, result_o.run_valid);
        check_field("run_start", want_res.run_start, result_o.run_start);
        check_field("run_bytes", want_res.run_bytes, result_o.run_bytes);
        check_field("range_complete", want_res.range_complete, result_o.range_complete);
        check_field("present_chunks", want_res.present_chunks, result_o.present_chunks);
        check_field("present_bytes", want_res.present_bytes, result_o.present_bytes);
        check_field("last", want_res.last, result_o.last);
      end
    end
  end

  // Watchdog: too long without any transaction or result
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int r;
    chunk_present = '0;
    value_size    = '0;
    chunk_total   = '0;

    // Directed rows: reset state, full-size value, clipped value, oversized
    // value with a count above the maximum, short count
    dir_tab[0]  = '{0, 0, 0, cmd(OP_MARK_SET, 0, 0, 0), 1, status(0, 0, 0)};
    dir_tab[1]  = '{0, 0, 0, cmd(OP_MARK_CLR, 63, 0, 0), 1, status(0, 0, 0)};
    dir_tab[2]  = '{0, 0, 0, cmd(OP_QUERY_MISSING, 0, 0, 0), 1, status(1, 0, 0)};
    dir_tab[3]  = '{0, 0, 0, cmd(OP_QUERY_MISSING, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                    1, status(0, 0, 0)};
    dir_tab[4]  = '{0, 0, 0, cmd(OP_LIST_PRESENT, 0, 0, 0), 1, status(0, 0, 0)};
    dir_tab[5]  = '{1, 23'd4194304, 7'd64, cmd(OP_QUERY_MISSING, 0, 0, 32'hFFFF_FFFF),
                    0, '0};
    dir_tab[6]  = '{0, 0, 0, cmd(OP_MARK_SET, 63, 0, 0), 1, status(0, 1, 65536)};
    dir_tab[7]  = '{0, 0, 0, cmd(OP_MARK_SET, 0, 0, 0), 1, status(0, 2, 131072)};
    dir_tab[8]  = '{0, 0, 0, cmd(OP_MARK_SET, 2, 0, 0), 0, '0};
    dir_tab[9]  = '{0, 0, 0, cmd(OP_LIST_PRESENT, 0, 0, 0), 0, '0};
    dir_tab[10] = '{0, 0, 0, cmd(OP_QUERY_MISSING, 0, 0, 65536), 0, '0};
    dir_tab[11] = '{0, 0, 0, cmd(OP_QUERY_MISSING, 0, 65535, 2), 0, '0};
    dir_tab[12] = '{0, 0, 0, cmd(OP_QUERY_MISSING, 0, 4194303, 1), 0, '0};
    dir_tab[13] = '{0, 0, 0, cmd(OP_QUERY_MISSING, 0, 4194304, 5), 1, status(0, 3, 196608)};
    dir_tab[14] = '{0, 0, 0, cmd(OP_MARK_CLR, 0, 0, 0), 0, '0};
    dir_tab[15] = '{0, 0, 0, cmd(OP_MARK_SET, 63, 0, 0), 0, '0};
    dir_tab[16] = '{1, 23'd100000, 7'd64, cmd(OP_MARK_SET, 1, 0, 0), 0, '0};
    dir_tab[17] = '{0, 0, 0, cmd(OP_MARK_SET, 63, 0, 0), 0, '0};
    dir_tab[18] = '{0, 0, 0, cmd(OP_MARK_SET, 5, 0, 0), 0, '0};
    dir_tab[19] = '{0, 0, 0, cmd(OP_LIST_PRESENT, 0, 0, 0), 0, '0};
    dir_tab[20] = '{0, 0, 0, cmd(OP_QUERY_MISSING, 0, 0, 32'hFFFF_FFFF), 0, '0};
    dir_tab[21] = '{1, 23'h7FFFFF, 7'd127, cmd(OP_MARK_SET, 63, 0, 0), 0, '0};
    dir_tab[22] = '{0, 0, 0, cmd(OP_QUERY_MISSING, 0, 0, 32'hFFFF_FFFF), 0, '0};
    dir_tab[23] = '{1, 23'd300000, 7'd3, cmd(OP_MARK_SET, 5, 0, 0), 1, status(0, 0, 0)};
    dir_tab[24] = '{0, 0, 0, cmd(OP_MARK_SET, 2, 0, 0), 0, '0};
    dir_tab[25] = '{0, 0, 0, cmd(OP_QUERY_MISSING, 0, 0, 300000), 0, '0};

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (r = 0; r < DIR_ROWS; r++) begin
      if (dir_tab[r].load) write_regs(dir_tab[r].total, dir_tab[r].count);
      issue(dir_tab[r].cmd, dir_tab[r].typed, dir_tab[r].want);
    end

    // Random phases; odd chunks present over an oversized value overflow the run cap
    run_phase(23'd4194304, 7'd64, 0, 1'b0, 1'b0, 10);
    run_phase(23'h7FFFFF, 7'd64, 67, 1'b1, 1'b1, 0);
    run_phase(23'($urandom_range(1, 600000)), 7'($urandom_range(1, 12)), 10, 1'b0, 1'b0, 10);
    run_phase(23'd4194304, 7'd64, 67, 1'b1, 1'b0, 0);
    run_phase(23'($urandom_range(0, 8388607)), 7'($urandom_range(0, 127)), 0, 1'b0, 1'b0,
              10);
    run_phase(23'd0, 7'd0, 10, 1'b0, 1'b0, 6);

    wait_idle();
    repeat (80) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
